@@ src/htw_pkg.sv @@
// Shared constants, types and state codes for the hashed timer wheel.
`default_nettype none
package htw_pkg;

  // Sizes of the timer table and the wheel.
  localparam int TIMERS    = 16;
  localparam int MAX_SLOTS = 4096;

  // Field widths.
  localparam int OP_W      = 2;
  localparam int ID_W      = 5;
  localparam int DATA_W    = 32;
  localparam int KIND_W    = 2;
  localparam int TICK_W    = 16;
  localparam int SCNT_W    = 13;
  localparam int SLOT_W    = 12;
  localparam int CFG_IDX_W = 2;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_SCHEDULE = 2'd0;
  localparam logic [OP_W-1:0] OP_CANCEL   = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK     = 2'd2;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_SCHEDULED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIRED     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR     = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRE_ENABLE = 2'd2;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_DISPATCH,
    ST_DIV_TICKS,
    ST_DIV_SLOTS,
    ST_WRITE,
    ST_ERROR,
    ST_SCAN,
    ST_ADVANCE
  } state_t;

  // Data broadcast from the controller to every timer cell.
  typedef struct packed {
    logic [SLOT_W-1:0] cur;
    logic [SLOT_W-1:0] wr_slot;
    logic [DATA_W-1:0] wr_rounds;
    logic [DATA_W-1:0] wr_payload;
  } cell_cmd_t;

endpackage
`default_nettype wire

@@ src/htw_div.sv @@
// Restoring divider, one quotient bit per cycle, 32-bit dividend by 16-bit divisor.
`default_nettype none
module htw_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      go,
  input  logic [htw_pkg::DATA_W-1:0] dividend,
  input  logic [htw_pkg::TICK_W-1:0] divisor,
  output logic                      done,
  output logic [htw_pkg::DATA_W-1:0] quotient,
  output logic [htw_pkg::TICK_W-1:0] remainder
);
  import htw_pkg::*;

  localparam int CNT_W = $clog2(DATA_W);

  logic              run;
  logic [CNT_W-1:0]  cnt;
  logic [TICK_W-1:0] div_q;
  logic [TICK_W:0]   trial;
  logic              fits;

  // Shift in the next dividend bit and try the subtraction.
  assign trial = {remainder, quotient[DATA_W-1]};
  assign fits  = trial >= {1'b0, div_q};

  // Sequencing of the iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= run && (cnt == CNT_W'(DATA_W - 1));
      if (go) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DATA_W - 1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  // Quotient and partial remainder.
  always_ff @(posedge clk) begin
    if (go) begin
      quotient  <= dividend;
      remainder <= '0;
      div_q     <= divisor;
    end else if (run) begin
      quotient <= {quotient[DATA_W-2:0], fits};
      if (fits) begin
        remainder <= TICK_W'(trial - {1'b0, div_q});
      end else begin
        remainder <= trial[TICK_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

@@ src/htw_cell.sv @@
// One timer table entry: valid mark, slot, rounds and payload, with scan token stage.
`default_nettype none
module htw_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  htw_pkg::cell_cmd_t         cmd,
  input  logic                       wr_sel,
  input  logic                       cancel_sel,
  input  logic                       tok_in,
  output logic                       tok_out,
  input  logic                       free_in,
  output logic                       free_out,
  output logic                       first_free,
  output logic                       fire,
  output logic [htw_pkg::DATA_W-1:0] payload
);
  import htw_pkg::*;

  logic              valid;
  logic [SLOT_W-1:0] slot;
  logic [DATA_W-1:0] rounds;
  logic              match;

  // Entry is due in the current slot.
  assign match = valid && (slot == cmd.cur);
  assign fire  = match && (rounds == '0);

  // Lowest free entry search ripples along the row.
  assign free_out   = free_in || !valid;
  assign first_free = !free_in && !valid;

  // The scan token moves one cell per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= 1'b0;
    end else begin
      tok_out <= tok_in;
    end
  end

  // Valid mark: set by schedule, cleared by cancel or when the timer fires.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr_sel) begin
      valid <= 1'b1;
    end else if (cancel_sel) begin
      valid <= 1'b0;
    end else if (tok_out && fire) begin
      valid <= 1'b0;
    end
  end

  // Timer contents; a visited entry with rounds left loses one.
  always_ff @(posedge clk) begin
    if (wr_sel) begin
      slot    <= cmd.wr_slot;
      rounds  <= cmd.wr_rounds;
      payload <= cmd.wr_payload;
    end else if (tok_out && match && (rounds != '0)) begin
      rounds <= rounds - 1'b1;
    end
  end

endmodule
`default_nettype wire

@@ src/hashed_timer_wheel.sv @@
// Hashed timer wheel: control, configuration, shared divider and a row of timer cells.
// Schedule: two divider passes from accept to its result, plus a reduction pass
//   when the current slot must first be reduced by a smaller slot count.
// Tick: the token walks the cell row one table entry per cycle, plus the
//   same reduction when needed; fired results come out during the walk, at most one per cycle.
// Cancel completes at its accept edge. Reset clears all timers, the current slot and
//   loads the register defaults. Results cannot be stalled by the receiver.
`default_nettype none
module hashed_timer_wheel (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [htw_pkg::OP_W-1:0]      op,
  input  logic [htw_pkg::ID_W-1:0]      timer_id,
  input  logic [htw_pkg::DATA_W-1:0]    timeout_ms,
  input  logic [htw_pkg::DATA_W-1:0]    user_payload,
  input  logic                          cfg_write,
  input  logic [htw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [htw_pkg::TICK_W-1:0]    cfg_data,
  output logic                          result_strobe,
  output logic [htw_pkg::KIND_W-1:0]    kind,
  output logic [htw_pkg::ID_W-1:0]      out_id,
  output logic [htw_pkg::DATA_W-1:0]    out_payload,
  output logic                          last
);
  import htw_pkg::*;

  // Configuration registers.
  logic [TICK_W-1:0] tick_length_ms;
  logic [SCNT_W-1:0] slot_count;
  logic              fire_enable;

  // Controller state and transaction registers.
  state_t            state, state_next;
  logic [OP_W-1:0]   op_q;
  logic [ID_W-1:0]   id_q;
  logic [DATA_W-1:0] delay_q;
  logic [DATA_W-1:0] payload_q;
  logic [SLOT_W-1:0] current_slot;
  logic [SLOT_W-1:0] cur;
  logic [DATA_W-1:0] rounds_q;
  logic [SLOT_W-1:0] slot_q;

  // Effective configuration.
  logic [SCNT_W-1:0] slots_eff;
  logic [TICK_W-1:0] tl_eff;

  // Divider connections.
  logic              div_go;
  logic [DATA_W-1:0] div_dividend;
  logic [TICK_W-1:0] div_divisor;
  logic              div_done;
  logic [DATA_W-1:0] div_quo;
  logic [TICK_W-1:0] div_rem;

  // Cell row connections.
  cell_cmd_t         cmd;
  logic [TIMERS-1:0] wr_sel;
  logic [TIMERS-1:0] cancel_sel;
  logic [TIMERS:0]   tok_chain;
  logic [TIMERS:0]   free_chain;
  logic [TIMERS-1:0] tok;
  logic [TIMERS-1:0] first_free;
  logic [TIMERS-1:0] fire;
  logic [DATA_W-1:0] cell_payload [TIMERS];

  // Derived control.
  logic              accept;
  logic              table_full;
  logic [ID_W-1:0]   alloc_id;
  logic              sched_err;
  logic              need_reduce;
  logic [DATA_W-1:0] ticks;
  logic [SCNT_W-1:0] slot_sum;
  logic [SCNT_W-1:0] slot_new;
  logic [SCNT_W-1:0] cur_inc;
  logic [TIMERS-1:0] later_mask;
  logic              scan_hit;
  logic              scan_last;
  logic [ID_W-1:0]   scan_id;
  logic [DATA_W-1:0] scan_payload;

  // Emitted result, registered onto the ports.
  logic              emit;
  logic [KIND_W-1:0] emit_kind;
  logic [ID_W-1:0]   emit_id;
  logic [DATA_W-1:0] emit_payload;
  logic              emit_last;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Zero slot count acts as one, anything above the wheel size as the wheel size.
  always_comb begin
    if (slot_count == '0) begin
      slots_eff = SCNT_W'(1);
    end else if (slot_count > SCNT_W'(MAX_SLOTS)) begin
      slots_eff = SCNT_W'(MAX_SLOTS);
    end else begin
      slots_eff = slot_count;
    end
    tl_eff = (tick_length_ms == '0) ? TICK_W'(1) : tick_length_ms;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_length_ms <= TICK_W'(1);
      slot_count     <= SCNT_W'(512);
      fire_enable    <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TICK_LENGTH: tick_length_ms <= cfg_data;
        CFG_SLOT_COUNT:  slot_count     <= cfg_data[SCNT_W-1:0];
        CFG_FIRE_ENABLE: fire_enable    <= cfg_data[0];
        default:         ;
      endcase
    end
  end

  // Allocation: id of the lowest free entry.
  always_comb begin
    alloc_id = '0;
    for (int i = 0; i < TIMERS; i++) begin
      if (first_free[i]) begin
        alloc_id = alloc_id | ID_W'(i + 1);
      end
    end
  end
  assign table_full  = !free_chain[TIMERS];
  assign sched_err   = (timer_id == '0) ? table_full : (timer_id > ID_W'(TIMERS));
  assign need_reduce = {1'b0, current_slot} >= slots_eff;

  // Tick count rounds up and is at least one.
  always_comb begin
    ticks = div_quo + DATA_W'(div_rem != '0);
    if (ticks == '0) begin
      ticks = DATA_W'(1);
    end
  end

  // New slot is the current slot plus the offset, wrapped once.
  assign slot_sum = {1'b0, cur} + div_rem[SCNT_W-1:0];
  assign slot_new = (slot_sum >= slots_eff) ? (slot_sum - slots_eff) : slot_sum;
  assign cur_inc  = {1'b0, cur} + SCNT_W'(1);

  // Divider operand selection.
  always_comb begin
    div_go       = 1'b0;
    div_dividend = delay_q;
    div_divisor  = tl_eff;
    case (state)
      ST_IDLE: begin
        div_go       = accept && need_reduce &&
                       ((op == OP_TICK) || ((op == OP_SCHEDULE) && !sched_err));
        div_dividend = DATA_W'(current_slot);
        div_divisor  = TICK_W'(slots_eff);
      end
      ST_DISPATCH: begin
        div_go = (op_q == OP_SCHEDULE);
      end
      ST_DIV_TICKS: begin
        div_go       = div_done;
        div_dividend = ticks;
        div_divisor  = TICK_W'(slots_eff);
      end
      default: ;
    endcase
  end

  htw_div u_div (
    .clk       (clk),
    .rst       (rst),
    .go        (div_go),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (op == OP_SCHEDULE) && sched_err) begin
          state_next = ST_ERROR;
        end else if (accept && ((op == OP_SCHEDULE) || (op == OP_TICK))) begin
          state_next = need_reduce ? ST_REDUCE : ST_DISPATCH;
        end
      end
      ST_REDUCE:    if (div_done) state_next = ST_DISPATCH;
      ST_DISPATCH:  state_next = (op_q == OP_TICK) ? ST_SCAN : ST_DIV_TICKS;
      ST_DIV_TICKS: if (div_done) state_next = ST_DIV_SLOTS;
      ST_DIV_SLOTS: if (div_done) state_next = ST_WRITE;
      ST_WRITE:     state_next = ST_IDLE;
      ST_ERROR:     state_next = ST_IDLE;
      ST_SCAN:      if (tok[TIMERS-1]) state_next = ST_ADVANCE;
      ST_ADVANCE:   state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Transaction registers and the wheel position.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_slot <= '0;
    end else if (state == ST_ADVANCE) begin
      current_slot <= (cur_inc == slots_eff) ? '0 : cur_inc[SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q      <= op;
      id_q      <= (timer_id == '0) ? alloc_id : timer_id;
      delay_q   <= timeout_ms;
      payload_q <= user_payload;
      cur       <= current_slot;
    end else if ((state == ST_REDUCE) && div_done) begin
      cur <= div_rem[SLOT_W-1:0];
    end
    if ((state == ST_DIV_SLOTS) && div_done) begin
      rounds_q <= div_quo;
      slot_q   <= slot_new[SLOT_W-1:0];
    end
  end

  // Cell selects and broadcast data.
  always_comb begin
    for (int i = 0; i < TIMERS; i++) begin
      wr_sel[i]     = (state == ST_WRITE) && (id_q == ID_W'(i + 1));
      cancel_sel[i] = accept && (op == OP_CANCEL) && (timer_id == ID_W'(i + 1));
    end
    cmd.cur        = cur;
    cmd.wr_slot    = slot_q;
    cmd.wr_rounds  = rounds_q;
    cmd.wr_payload = payload_q;
  end

  assign tok_chain[0]  = (state == ST_DISPATCH) && (op_q == OP_TICK);
  assign free_chain[0] = 1'b0;
  assign tok           = tok_chain[TIMERS:1];

  // Row of timer cells.
  for (genvar g = 0; g < TIMERS; g++) begin : g_cell
    htw_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .wr_sel     (wr_sel[g]),
      .cancel_sel (cancel_sel[g]),
      .tok_in     (tok_chain[g]),
      .tok_out    (tok_chain[g+1]),
      .free_in    (free_chain[g]),
      .free_out   (free_chain[g+1]),
      .first_free (first_free[g]),
      .fire       (fire[g]),
      .payload    (cell_payload[g])
    );
  end

  // Firing during the scan; last when no later cell fires.
  always_comb begin
    scan_id      = '0;
    scan_payload = '0;
    for (int i = 0; i < TIMERS; i++) begin
      if (tok[i]) begin
        scan_id      = scan_id | ID_W'(i + 1);
        scan_payload = scan_payload | cell_payload[i];
      end
    end
  end
  assign later_mask = ~(tok | (tok - 1'b1));
  assign scan_hit   = (|(tok & fire)) && fire_enable;
  assign scan_last  = !(|(fire & later_mask));

  // Result selection.
  always_comb begin
    emit         = 1'b0;
    emit_kind    = KIND_SCHEDULED;
    emit_id      = '0;
    emit_payload = '0;
    emit_last    = 1'b0;
    case (state)
      ST_WRITE: begin
        emit      = 1'b1;
        emit_id   = id_q;
        emit_last = 1'b1;
      end
      ST_ERROR: begin
        emit      = 1'b1;
        emit_kind = KIND_ERROR;
        emit_last = 1'b1;
      end
      ST_SCAN: begin
        emit         = scan_hit;
        emit_kind    = KIND_FIRED;
        emit_id      = scan_id;
        emit_payload = scan_payload;
        emit_last    = scan_last;
      end
      default: ;
    endcase
  end

  // Result output registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= emit;
    end
    kind        <= emit_kind;
    out_id      <= emit_id;
    out_payload <= emit_payload;
    last        <= emit_last;
  end

  // A result only follows a cycle of work.
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(busy))
    else $error("result without transaction in progress");

  // At most one cell holds the scan token.
  a_token_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok))
    else $error("scan token duplicated");

  // An accepted tick keeps the block busy.
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (op == OP_TICK)) |=> busy)
    else $error("tick accepted without starting a scan");

  // An error result carries no id and ends the transaction.
  a_error_form: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && (kind == KIND_ERROR)) |-> ((out_id == '0) && last))
    else $error("malformed error result");

endmodule
`default_nettype wire

@@ tb/tb_hashed_timer_wheel.sv @@
// Self-checking testbench for the hashed timer wheel: directed and random transactions.
`default_nettype none
module tb_hashed_timer_wheel;
  timeunit 1ns;
  timeprecision 1ps;
  import htw_pkg::*;

  // One result transaction as seen on the output ports.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   id;
    logic [DATA_W-1:0] payload;
    logic              last;
  } wheel_result_t;

  int error_count = 0;

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    error_count++;
  endtask

  // Scoreboard: mirrors the timer table and holds pending results.
  class wheel_scoreboard;
    logic [TICK_W-1:0] tick_len;
    logic [SCNT_W-1:0] slot_cnt;
    logic              fire_en;
    logic              valid_q[TIMERS];
    logic [31:0]       slot_q[TIMERS];
    logic [31:0]       rounds_q[TIMERS];
    logic [31:0]       payload_q[TIMERS];
    logic [31:0]       cur_slot;
    wheel_result_t     pending[$];

    function new();
      tick_len = 1;
      slot_cnt = 512;
      fire_en = 1;
      cur_slot = 0;
      foreach (valid_q[i]) begin
        valid_q[i] = 0;
        slot_q[i] = 0;
        rounds_q[i] = 0;
        payload_q[i] = 0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] data);
      if (idx == CFG_TICK_LENGTH) tick_len = data;
      else if (idx == CFG_SLOT_COUNT) slot_cnt = data[SCNT_W-1:0];
      else if (idx == CFG_FIRE_ENABLE) fire_en = data[0];
    endfunction

    function int free_count();
      int n;
      n = 0;
      foreach (valid_q[i]) if (!valid_q[i]) n++;
      return n;
    endfunction

    // Predict the results of one accepted command.
    function void note_input(logic [OP_W-1:0] op, logic [ID_W-1:0] tid,
                             logic [31:0] dly, logic [31:0] pay);
      longint unsigned slots, cur, tl, ticks;
      int e, n, last_ix;
      wheel_result_t r;
      slots = (slot_cnt == 0) ? 1 : (slot_cnt > MAX_SLOTS ? MAX_SLOTS : slot_cnt);
      cur = cur_slot % slots;
      if (op == OP_SCHEDULE) begin
        e = -1;
        if (tid == 0) begin
          for (int i = 0; i < TIMERS; i++)
            if (!valid_q[i] && e < 0) e = i;
        end else if (tid <= TIMERS) e = tid - 1;
        if (e < 0) begin
          r = '{KIND_ERROR, '0, '0, 1'b1};
          pending = {pending, r};
          return;
        end
        tl = (tick_len == 0) ? 1 : tick_len;
        ticks = (longint'(dly) + tl - 1) / tl;
        if (ticks == 0) ticks = 1;
        valid_q[e] = 1;
        rounds_q[e] = ticks / slots;
        slot_q[e] = (cur + ticks % slots) % slots;
        payload_q[e] = pay;
        r = '{KIND_SCHEDULED, ID_W'(e + 1), '0, 1'b1};
        pending = {pending, r};
      end else if (op == OP_CANCEL) begin
        if (tid != 0 && tid <= TIMERS) valid_q[tid - 1] = 0;
      end else if (op == OP_TICK) begin
        n = 0;
        last_ix = -1;
        for (int i = 0; i < TIMERS; i++) begin
          if (valid_q[i] && slot_q[i] == cur) begin
            if (rounds_q[i] > 0) rounds_q[i]--;
            else begin
              valid_q[i] = 0;
              if (fire_en) begin
                r = '{KIND_FIRED, ID_W'(i + 1), payload_q[i], 1'b0};
                pending = {pending, r};
                last_ix = pending.size() - 1;
                n++;
              end
            end
          end
        end
        if (n > 0) pending[last_ix].last = 1;
        cur_slot = (cur + 1) % slots;
      end
    endfunction

    // Compare one result transaction with the oldest prediction.
    task check_result(wheel_result_t got);
      wheel_result_t exp_r;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind=%0d id=%0d", got.kind, got.id));
        return;
      end
      exp_r = pending.pop_front();
      if (got.kind !== exp_r.kind)
        report_mismatch($sformatf("kind %0d, want %0d", got.kind, exp_r.kind));
      if (got.id !== exp_r.id)
        report_mismatch($sformatf("out_id %0d, want %0d", got.id, exp_r.id));
      if (got.payload !== exp_r.payload)
        report_mismatch($sformatf("out_payload %h, want %h", got.payload, exp_r.payload));
      if (got.last !== exp_r.last)
        report_mismatch($sformatf("last %0d, want %0d", got.last, exp_r.last));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic [OP_W-1:0] op = '0;
  logic [ID_W-1:0] timer_id = '0;
  logic [DATA_W-1:0] timeout_ms = '0;
  logic [DATA_W-1:0] user_payload = '0;
  logic cfg_write = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TICK_W-1:0] cfg_data = '0;
  logic result_strobe;
  logic [KIND_W-1:0] kind;
  logic [ID_W-1:0] out_id;
  logic [DATA_W-1:0] out_payload;
  logic last;

  wheel_scoreboard sb = new();
  int gap_pct = 0;
  int stall_cycles = 0;

  hashed_timer_wheel dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .op(op), .timer_id(timer_id), .timeout_ms(timeout_ms), .user_payload(user_payload),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_strobe(result_strobe), .kind(kind), .out_id(out_id),
    .out_payload(out_payload), .last(last)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Result monitor and inactivity watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_strobe) sb.check_result('{kind, out_id, out_payload, last});
      if (result_strobe || (start && !busy)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles > 20000) begin
        $display("tb_hashed_timer_wheel: FAIL");
        $finish;
      end
    end
  end

  // Issue one command and wait for its acceptance; start stays high until the
  // next command or the drain takes it down.
  task automatic send_cmd(input logic [OP_W-1:0] o, input logic [ID_W-1:0] tid,
                          input logic [31:0] dly, input logic [31:0] pay);
    while ($urandom_range(99) < gap_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    op <= o;
    timer_id <= tid;
    timeout_ms <= dly;
    user_payload <= pay;
    do @(posedge clk); while (busy);
    sb.note_input(o, tid, dly, pay);
  endtask

  // Wait until the block is idle with nothing outstanding.
  task automatic drain();
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] data);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_write <= 0;
    @(posedge clk);
  endtask

  // Random command mix: mostly ticks and schedules (delays mostly short), some cancels and the unused op code.
  task automatic random_cmd();
    int sel;
    logic [31:0] dly;
    logic [ID_W-1:0] tid;
    sel = $urandom_range(99);
    tid = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(TIMERS));
    if ($urandom_range(9) == 0) dly = $urandom;
    else dly = $urandom_range(40);
    if (sel < 40) send_cmd(OP_SCHEDULE, tid, dly, $urandom);
    else if (sel < 50) send_cmd(OP_CANCEL, tid, $urandom, $urandom);
    else if (sel < 97) send_cmd(OP_TICK, tid, $urandom, $urandom);
    else send_cmd(2'd3, tid, $urandom, $urandom);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: small wheel, extremes of delay, reschedule, cancel and full table.
    write_cfg(CFG_SLOT_COUNT, 4);
    send_cmd(OP_SCHEDULE, 0, 0, 32'hFFFF_FFFF);
    send_cmd(OP_SCHEDULE, 0, 32'hFFFF_FFFF, 32'h0);
    send_cmd(OP_SCHEDULE, 5'd16, 3, 32'hA5A5_5A5A);
    send_cmd(OP_SCHEDULE, 5'd16, 1, 32'h5A5A_A5A5);
    send_cmd(OP_SCHEDULE, 5'd17, 1, 0);
    send_cmd(OP_SCHEDULE, 5'd31, 1, 0);
    send_cmd(OP_CANCEL, 5'd2, 0, 0);
    send_cmd(OP_CANCEL, 5'd0, 0, 0);
    send_cmd(OP_CANCEL, 5'd31, 0, 0);
    send_cmd(2'd3, 5'd1, 0, 0);
    for (int i = 0; i < 5; i++) send_cmd(OP_TICK, 0, 0, 0);
    for (int i = 0; i < 17; i++) send_cmd(OP_SCHEDULE, 0, 2, i);
    send_cmd(OP_TICK, 0, 0, 0);
    send_cmd(OP_TICK, 0, 0, 0);
    send_cmd(OP_TICK, 0, 0, 0);
    drain();

    // Random phases over several register settings, including the extremes.
    for (int ph = 0; ph < 6; ph++) begin
      gap_pct = (ph < 2) ? 20 : (ph < 4 ? 87 : 0);
      case (ph)
        0: begin write_cfg(CFG_TICK_LENGTH, 0); write_cfg(CFG_SLOT_COUNT, 0);
                 write_cfg(CFG_FIRE_ENABLE, 1); end
        1: begin write_cfg(CFG_TICK_LENGTH, 16'hFFFF); write_cfg(CFG_SLOT_COUNT, 16'h1FFF); end
        2: begin write_cfg(CFG_TICK_LENGTH, 3); write_cfg(CFG_SLOT_COUNT, 8); end
        3: begin write_cfg(CFG_FIRE_ENABLE, 0); write_cfg(CFG_SLOT_COUNT, 3); end
        4: begin write_cfg(CFG_FIRE_ENABLE, 1); write_cfg(CFG_SLOT_COUNT, 4096);
                 write_cfg(CFG_TICK_LENGTH, 1); end
        default: begin write_cfg(CFG_SLOT_COUNT, 5); write_cfg(CFG_TICK_LENGTH, 2); end
      endcase
      for (int i = 0; i < 31; i++) random_cmd();
      drain();
    end

    if (error_count == 0) $display("tb_hashed_timer_wheel: PASS");
    else $display("tb_hashed_timer_wheel: FAIL");
    $finish;
  end
endmodule
`default_nettype wire
